// ===== design/ptcf_pkg.sv =====
// Shared constants, codes and width helpers for the compensated flow block.
package ptcf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_INDEX_W    = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COMP_TYPE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_UNIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_PRESS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_TEMP  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OOS        = 3'd5;

    // compensation types
    localparam logic [1:0] COMP_PT = 2'd0;
    localparam logic [1:0] COMP_P  = 2'd1;
    localparam logic [1:0] COMP_T  = 2'd2;

    // pressure units
    localparam logic [2:0] UNIT_KGF = 3'd1;
    localparam logic [2:0] UNIT_KPA = 3'd3;
    localparam logic [2:0] UNIT_MPA = 3'd4;
    localparam logic [2:0] UNIT_RESET = UNIT_KPA;

    // signed width of the pressure numerator and denominator
    function automatic int press_w(input int w, input int f);
        return ((w > f + 8) ? w : f + 8) + 11;
    endfunction

    // signed width of the absolute temperatures
    function automatic int temp_w(input int w, input int f);
        return ((w > f + 10) ? w : f + 10) + 2;
    endfunction

    function automatic int num_w(input int w, input int f);
        return press_w(w, f) + temp_w(w, f);
    endfunction

    function automatic int quot_w(input int w, input int f);
        return num_w(w, f) + 2 * f;
    endfunction

    function automatic int sat_w(input int w, input int f);
        return (quot_w(w, f) > 128) ? 128 : quot_w(w, f);
    endfunction

    function automatic int root_w(input int w, input int f);
        return (sat_w(w, f) + 1) / 2;
    endfunction

    // flow sign, root error, zero factor, flow magnitude
    function automatic int side_w(input int w);
        return w + 3;
    endfunction

endpackage

// ===== design/pt_compensated_flow.sv =====
// Pressure and temperature compensated gas flow, fully pipelined.
//
// Input channel in_valid/in_ready carries raw_flow, meas_temp and meas_press
// (signed fixed point). Each request gives one result on out_valid/out_ready:
// comp_flow with bad_status, unit_error and root_error.
// Configuration is written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write only while no request is in flight.
// Throughput: one request per cycle while the pipeline is not held. Requests
// pass the front stages, the ratio divider (one bit per stage), the square
// root (one bit per stage), the back stages and the output register.
// The whole pipeline moves on one enable: it holds when the output register
// is full and not taken, so in_ready drops for as long as out_ready is low
// with a result waiting, and nothing is lost or repeated.
// Reset empties the pipeline, loads the register defaults (pressure and
// temperature compensation, kPa, unity gain, in service) and clears the
// held last flow.
module pt_compensated_flow #(
    parameter int DATA_WIDTH = ptcf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ptcf_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [DATA_WIDTH-1:0]      raw_flow,
    input  logic signed [DATA_WIDTH-1:0]      meas_temp,
    input  logic signed [DATA_WIDTH-1:0]      meas_press,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [DATA_WIDTH-1:0]      comp_flow,
    output logic                              bad_status,
    output logic                              unit_error,
    output logic                              root_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptcf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0]             cfg_data
);

    localparam int W      = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int PW     = ptcf_pkg::press_w(W, F);
    localparam int TW     = ptcf_pkg::temp_w(W, F);
    localparam int NW     = ptcf_pkg::num_w(W, F);
    localparam int RW     = ptcf_pkg::root_w(W, F);
    localparam int SIDE_W = ptcf_pkg::side_w(W);
    localparam int XW     = ((W > F + 6) ? W : F + 6) + 4;
    localparam int QA     = XW - 3;
    localparam int K9     = XW + 4;
    localparam int PH     = PW / 2;
    localparam int FH     = RW / 2;
    localparam int M1W    = RW + W - F;
    localparam int GH     = M1W / 2;
    localparam int RSW    = M1W + W - F;

    localparam longint unsigned OFF_KPA = ((64'd101324 << F) + 64'd500) / 64'd1000;
    localparam longint unsigned OFF_KGF = ((64'd10332 << F) + 64'd5000) / 64'd10000;
    localparam longint unsigned KELVIN  = ((64'd27315 << F) + 64'd50) / 64'd100;
    localparam longint unsigned F32     = 64'd32 << F;
    localparam longint unsigned M9      = ((64'd1 << K9) / 64'd9) + 64'd1;

    localparam logic signed [PW-1:0] P_OFF_KPA = PW'(OFF_KPA);
    localparam logic signed [PW-1:0] P_OFF_KGF = PW'(OFF_KGF);
    localparam logic signed [PW-1:0] P_ONE     = PW'(1);
    localparam logic signed [TW-1:0] T_KELVIN  = TW'(KELVIN);
    localparam logic signed [TW-1:0] T_ONE     = TW'(1);
    localparam logic signed [XW-1:0] X_F32     = XW'(F32);
    localparam logic [XW:0]          X_M9      = (XW+1)'(M9);

    // configuration registers
    logic [1:0]          comp_type_reg;
    logic [2:0]          press_unit_reg;
    logic signed [W-1:0] base_press_reg;
    logic signed [W-1:0] base_temp_reg;
    logic signed [W-1:0] gain_reg;
    logic                oos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_type_reg  <= ptcf_pkg::COMP_PT;
            press_unit_reg <= ptcf_pkg::UNIT_RESET;
            base_press_reg <= '0;
            base_temp_reg  <= '0;
            gain_reg       <= W'(64'd1 << F);
            oos_reg        <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ptcf_pkg::REG_COMP_TYPE:  comp_type_reg  <= cfg_data[1:0];
                ptcf_pkg::REG_PRESS_UNIT: press_unit_reg <= cfg_data[2:0];
                ptcf_pkg::REG_BASE_PRESS: base_press_reg <= cfg_data;
                ptcf_pkg::REG_BASE_TEMP:  base_temp_reg  <= cfg_data;
                ptcf_pkg::REG_GAIN:       gain_reg       <= cfg_data;
                ptcf_pkg::REG_OOS:        oos_reg        <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic                is_kgf;
    logic                is_mpa;
    logic                unit_bad;
    logic signed [PW-1:0] p_off;
    logic                g_neg;
    logic [W-1:0]        g_mag;

    assign is_kgf   = press_unit_reg == ptcf_pkg::UNIT_KGF;
    assign is_mpa   = press_unit_reg == ptcf_pkg::UNIT_MPA;
    assign unit_bad = (comp_type_reg != ptcf_pkg::COMP_PT && comp_type_reg != ptcf_pkg::COMP_P
                       && comp_type_reg != ptcf_pkg::COMP_T)
                      || !(is_kgf || is_mpa || press_unit_reg == ptcf_pkg::UNIT_KPA);
    assign p_off    = is_kgf ? P_OFF_KGF : P_OFF_KPA;
    assign g_neg    = gain_reg[W-1];
    assign g_mag    = g_neg ? W'(-gain_reg) : W'(gain_reg);

    // single enable: advance whenever the output register can take a request
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;
    logic s8_v_reg, s9_v_reg, s10_v_reg;
    logic root_v;

    // stage 1: capture request
    logic signed [W-1:0] s1_flow_reg, s1_temp_reg, s1_press_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_flow_reg  <= raw_flow;
            s1_temp_reg  <= meas_temp;
            s1_press_reg <= meas_press;
        end
    end

    // stage 2: pressure offsets, Fahrenheit shift and scale
    logic signed [PW-1:0] pm_ext, pm_sc, pn_c, pd_c;
    logic signed [XW-1:0] xa, xb;
    logic                 xa_neg, xb_neg;

    assign pm_ext = PW'(s1_press_reg);
    assign pm_sc  = is_mpa ? PW'(pm_ext * 1000) : pm_ext;
    assign pn_c   = pm_sc + p_off;
    assign pd_c   = PW'(base_press_reg) + p_off;
    assign xa     = XW'((XW'(base_temp_reg) - X_F32) * 5);
    assign xb     = XW'((XW'(s1_temp_reg) - X_F32) * 5);
    assign xa_neg = xa[XW-1];
    assign xb_neg = xb[XW-1];

    logic signed [PW-1:0] s2_pn_reg, s2_pd_reg;
    logic [XW-1:0]        s2_va_reg, s2_vb_reg;
    logic                 s2_an_reg, s2_bn_reg;
    logic signed [W-1:0]  s2_temp_reg;
    logic [W-1:0]         s2_fmag_reg;
    logic                 s2_fneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pn_reg   <= pn_c;
            s2_pd_reg   <= pd_c;
            s2_va_reg   <= XW'(xa_neg ? -xa : xa) + XW'(4);
            s2_vb_reg   <= XW'(xb_neg ? -xb : xb) + XW'(4);
            s2_an_reg   <= xa_neg;
            s2_bn_reg   <= xb_neg;
            s2_temp_reg <= s1_temp_reg;
            s2_fmag_reg <= s1_flow_reg[W-1] ? W'(-s1_flow_reg) : W'(s1_flow_reg);
            s2_fneg_reg <= s1_flow_reg[W-1];
        end
    end

    // stage 3: divide by nine through the reciprocal
    logic [2*XW:0] qa_prod, qb_prod;

    assign qa_prod = s2_va_reg * X_M9;
    assign qb_prod = s2_vb_reg * X_M9;

    logic signed [PW-1:0] s3_pn_reg, s3_pd_reg;
    logic [QA-1:0]        s3_qa_reg, s3_qb_reg;
    logic                 s3_an_reg, s3_bn_reg;
    logic signed [W-1:0]  s3_temp_reg;
    logic [W-1:0]         s3_fmag_reg;
    logic                 s3_fneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_pn_reg   <= s2_pn_reg;
            s3_pd_reg   <= s2_pd_reg;
            s3_qa_reg   <= qa_prod[K9 +: QA];
            s3_qb_reg   <= qb_prod[K9 +: QA];
            s3_an_reg   <= s2_an_reg;
            s3_bn_reg   <= s2_bn_reg;
            s3_temp_reg <= s2_temp_reg;
            s3_fmag_reg <= s2_fmag_reg;
            s3_fneg_reg <= s2_fneg_reg;
        end
    end

    // stage 4: absolute temperatures, select the active ratios
    logic signed [TW-1:0] a_c, b_c, tn_c, td_c;
    logic signed [PW-1:0] pn_s, pd_s;
    logic signed [TW-1:0] tn_s, td_s;

    assign a_c  = s3_an_reg ? -$signed(TW'(s3_qa_reg)) : $signed(TW'(s3_qa_reg));
    assign b_c  = s3_bn_reg ? -$signed(TW'(s3_qb_reg)) : $signed(TW'(s3_qb_reg));
    assign tn_c = (is_kgf ? a_c : TW'(base_temp_reg)) + T_KELVIN;
    assign td_c = (is_kgf ? b_c : TW'(s3_temp_reg)) + T_KELVIN;
    assign pn_s = (comp_type_reg == ptcf_pkg::COMP_T) ? P_ONE : s3_pn_reg;
    assign pd_s = (comp_type_reg == ptcf_pkg::COMP_T) ? P_ONE : s3_pd_reg;
    assign tn_s = (comp_type_reg == ptcf_pkg::COMP_P) ? T_ONE : tn_c;
    assign td_s = (comp_type_reg == ptcf_pkg::COMP_P) ? T_ONE : td_c;

    logic signed [PW-1:0] s4_pn_reg, s4_pd_reg;
    logic signed [TW-1:0] s4_tn_reg, s4_td_reg;
    logic [W-1:0]         s4_fmag_reg;
    logic                 s4_fneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_pn_reg   <= pn_s;
            s4_pd_reg   <= pd_s;
            s4_tn_reg   <= tn_s;
            s4_td_reg   <= td_s;
            s4_fmag_reg <= s3_fmag_reg;
            s4_fneg_reg <= s3_fneg_reg;
        end
    end

    // stage 5: ratio checks and magnitudes
    logic den_zero, num_zero, sign_odd;

    assign den_zero = (s4_pd_reg == '0) || (s4_td_reg == '0);
    assign num_zero = (s4_pn_reg == '0) || (s4_tn_reg == '0);
    assign sign_odd = s4_pn_reg[PW-1] ^ s4_pd_reg[PW-1] ^ s4_tn_reg[TW-1] ^ s4_td_reg[TW-1];

    logic [PW-1:0] s5_pnm_reg, s5_pdm_reg;
    logic [TW-1:0] s5_tnm_reg, s5_tdm_reg;
    logic          s5_rerr_reg, s5_fzero_reg;
    logic [W-1:0]  s5_fmag_reg;
    logic          s5_fneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_pnm_reg   <= PW'(s4_pn_reg[PW-1] ? -s4_pn_reg : s4_pn_reg);
            s5_pdm_reg   <= PW'(s4_pd_reg[PW-1] ? -s4_pd_reg : s4_pd_reg);
            s5_tnm_reg   <= TW'(s4_tn_reg[TW-1] ? -s4_tn_reg : s4_tn_reg);
            s5_tdm_reg   <= TW'(s4_td_reg[TW-1] ? -s4_td_reg : s4_td_reg);
            s5_rerr_reg  <= den_zero || (!num_zero && sign_odd);
            s5_fzero_reg <= den_zero || num_zero || sign_odd;
            s5_fmag_reg  <= s4_fmag_reg;
            s5_fneg_reg  <= s4_fneg_reg;
        end
    end

    // stage 6: partial products of numerator and denominator
    logic [PH+TW-1:0]    s6_nlo_reg, s6_dlo_reg;
    logic [PW-PH+TW-1:0] s6_nhi_reg, s6_dhi_reg;
    logic [SIDE_W-1:0]   s6_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_nlo_reg  <= s5_pnm_reg[PH-1:0] * s5_tnm_reg;
            s6_nhi_reg  <= s5_pnm_reg[PW-1:PH] * s5_tnm_reg;
            s6_dlo_reg  <= s5_pdm_reg[PH-1:0] * s5_tdm_reg;
            s6_dhi_reg  <= s5_pdm_reg[PW-1:PH] * s5_tdm_reg;
            s6_side_reg <= {s5_fneg_reg, s5_rerr_reg, s5_fzero_reg, s5_fmag_reg};
        end
    end

    // stage 7: sum partial products
    logic [NW-1:0]     s7_num_reg, s7_den_reg;
    logic [SIDE_W-1:0] s7_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_num_reg  <= NW'(s6_nlo_reg) + (NW'(s6_nhi_reg) << PH);
            s7_den_reg  <= NW'(s6_dlo_reg) + (NW'(s6_dhi_reg) << PH);
            s7_side_reg <= s6_side_reg;
        end
    end

    logic [RW-1:0]     root_f;
    logic [SIDE_W-1:0] root_side;

    ptcf_root #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_v_reg),
        .num       (s7_num_reg),
        .den       (s7_den_reg),
        .in_side   (s7_side_reg),
        .out_valid (root_v),
        .root      (root_f),
        .out_side  (root_side)
    );

    // stage 8: factor times flow, partial products
    logic          r_fneg, r_rerr, r_fzero;
    logic [W-1:0]  r_fmag;
    logic [RW-1:0] f_eff;

    assign {r_fneg, r_rerr, r_fzero, r_fmag} = root_side;
    assign f_eff = r_fzero ? '0 : root_f;

    logic [FH+W-1:0]    s8_mlo_reg;
    logic [RW-FH+W-1:0] s8_mhi_reg;
    logic               s8_fneg_reg, s8_rerr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_mlo_reg  <= f_eff[FH-1:0] * r_fmag;
            s8_mhi_reg  <= f_eff[RW-1:FH] * r_fmag;
            s8_fneg_reg <= r_fneg;
            s8_rerr_reg <= r_rerr;
        end
    end

    // stage 9: scale back; an unsupported unit or compensation type forces a factor-times-flow of one
    logic [RW+W-1:0] m_sum;

    assign m_sum = (RW+W)'(s8_mlo_reg) + ((RW+W)'(s8_mhi_reg) << FH);

    logic [M1W-1:0] s9_m1_reg;
    logic           s9_neg_reg, s9_rerr_reg, s9_uerr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_m1_reg   <= unit_bad ? (M1W'(1) << F) : m_sum[RW+W-1:F];
            s9_neg_reg  <= unit_bad ? g_neg : (s8_fneg_reg ^ g_neg);
            s9_rerr_reg <= unit_bad ? 1'b0 : s8_rerr_reg;
            s9_uerr_reg <= unit_bad;
        end
    end

    // stage 10: gain partial products
    logic [GH+W-1:0]     s10_glo_reg;
    logic [M1W-GH+W-1:0] s10_ghi_reg;
    logic                s10_neg_reg, s10_rerr_reg, s10_uerr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_glo_reg  <= s9_m1_reg[GH-1:0] * g_mag;
            s10_ghi_reg  <= s9_m1_reg[M1W-1:GH] * g_mag;
            s10_neg_reg  <= s9_neg_reg;
            s10_rerr_reg <= s9_rerr_reg;
            s10_uerr_reg <= s9_uerr_reg;
        end
    end

    // stage 11: saturate, apply sign, hold the last flow when out of service, output register
    logic [M1W+W-1:0] g_sum;
    logic [RSW-1:0]   res_mag, res_lim, res_sat;
    logic [W-1:0]     res_val;

    assign g_sum   = (M1W+W)'(s10_glo_reg) + ((M1W+W)'(s10_ghi_reg) << GH);
    assign res_mag = g_sum[M1W+W-1:F];
    assign res_lim = s10_neg_reg ? (RSW'(1) << (W - 1)) : ((RSW'(1) << (W - 1)) - RSW'(1));
    assign res_sat = (res_mag > res_lim) ? res_lim : res_mag;
    assign res_val = s10_neg_reg ? W'(-res_sat) : W'(res_sat);

    logic signed [W-1:0] comp_flow_reg;
    logic signed [W-1:0] last_flow_reg;
    logic                bad_status_reg, unit_error_reg, root_error_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            comp_flow_reg  <= oos_reg ? last_flow_reg : res_val;
            bad_status_reg <= oos_reg;
            unit_error_reg <= !oos_reg && s10_uerr_reg;
            root_error_reg <= !oos_reg && s10_rerr_reg;
        end
    end

    // valid bits and the held last flow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            s7_v_reg      <= 1'b0;
            s8_v_reg      <= 1'b0;
            s9_v_reg      <= 1'b0;
            s10_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            last_flow_reg <= '0;
        end
        else if (en)
        begin
            s1_v_reg      <= in_valid;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg;
            s6_v_reg      <= s5_v_reg;
            s7_v_reg      <= s6_v_reg;
            s8_v_reg      <= root_v;
            s9_v_reg      <= s8_v_reg;
            s10_v_reg     <= s9_v_reg;
            out_valid_reg <= s10_v_reg;
            if (s10_v_reg && !oos_reg)
            begin
                last_flow_reg <= res_val;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign comp_flow  = comp_flow_reg;
    assign bad_status = bad_status_reg;
    assign unit_error = unit_error_reg;
    assign root_error = root_error_reg;

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_status |-> !unit_error && !root_error)
        else $error("out of service result carries an error flag");

    a_unit_gain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unit_error |-> comp_flow == gain_reg)
        else $error("unsupported unit result differs from gain");

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        oos_reg |=> $stable(last_flow_reg))
        else $error("last flow changed while out of service");

endmodule

// ===== design/ptcf_root.sv =====
// Pipelined ratio divider and square root: floor(sqrt(num * 2^(2F) / den)).
module ptcf_root #(
    parameter int DATA_WIDTH = ptcf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ptcf_pkg::FRAC_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             en,
    input  logic                                             in_valid,
    input  logic [ptcf_pkg::num_w(DATA_WIDTH, FRAC_BITS)-1:0]  num,
    input  logic [ptcf_pkg::num_w(DATA_WIDTH, FRAC_BITS)-1:0]  den,
    input  logic [ptcf_pkg::side_w(DATA_WIDTH)-1:0]            in_side,
    output logic                                             out_valid,
    output logic [ptcf_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] root,
    output logic [ptcf_pkg::side_w(DATA_WIDTH)-1:0]            out_side
);

    localparam int NW     = ptcf_pkg::num_w(DATA_WIDTH, FRAC_BITS);
    localparam int QW     = ptcf_pkg::quot_w(DATA_WIDTH, FRAC_BITS);
    localparam int SQ     = ptcf_pkg::sat_w(DATA_WIDTH, FRAC_BITS);
    localparam int RW     = ptcf_pkg::root_w(DATA_WIDTH, FRAC_BITS);
    localparam int SIDE_W = ptcf_pkg::side_w(DATA_WIDTH);
    localparam int F2     = 2 * FRAC_BITS;
    localparam int RMW    = RW + 2;

    // divider stages, one quotient bit each
    logic              dv_reg   [QW];
    logic [NW-1:0]     rem_reg  [QW];
    logic [QW-1:0]     quo_reg  [QW];
    logic [NW-1:0]     n_reg    [QW];
    logic [NW-1:0]     d_reg    [QW];
    logic [SIDE_W-1:0] dside_reg[QW];

    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int K = QW - 1 - i;
        logic              v_in;
        logic [NW-1:0]     rem_in;
        logic [QW-1:0]     quo_in;
        logic [NW-1:0]     n_in;
        logic [NW-1:0]     d_in;
        logic [SIDE_W-1:0] side_in;
        logic              dbit;
        logic [NW:0]       shifted;
        logic              ge;
        logic [NW:0]       diff;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign quo_in  = '0;
            assign n_in    = num;
            assign d_in    = den;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = dv_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign quo_in  = quo_reg[i-1];
            assign n_in    = n_reg[i-1];
            assign d_in    = d_reg[i-1];
            assign side_in = dside_reg[i-1];
        end

        if (K >= F2) begin : g_bit
            assign dbit = n_in[K-F2];
        end else begin : g_pad
            assign dbit = 1'b0;
        end

        assign shifted = {rem_in, dbit};
        assign ge      = shifted >= {1'b0, d_in};
        assign diff    = shifted - {1'b0, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]   <= ge ? diff[NW-1:0] : shifted[NW-1:0];
                quo_reg[i]   <= {quo_in[QW-2:0], ge};
                n_reg[i]     <= n_in;
                d_reg[i]     <= d_in;
                dside_reg[i] <= side_in;
            end
        end
    end

    // clamp the quotient to at most 128 bits
    logic [SQ-1:0]     q_sat;
    logic [2*RW-1:0]   q_pad;

    if (QW > SQ) begin : g_sat
        assign q_sat = (|quo_reg[QW-1][QW-1:SQ]) ? '1 : quo_reg[QW-1][SQ-1:0];
    end else begin : g_nosat
        assign q_sat = quo_reg[QW-1];
    end
    assign q_pad = (2*RW)'(q_sat);

    // square root stages, one root bit each
    logic              sv_reg   [RW];
    logic [RMW-1:0]    srem_reg [RW];
    logic [RW-1:0]     sroot_reg[RW];
    logic [2*RW-1:0]   sq_reg   [RW];
    logic [SIDE_W-1:0] sside_reg[RW];

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int P = RW - 1 - j;
        logic              v_in;
        logic [RMW-1:0]    rem_in;
        logic [RW-1:0]     root_in;
        logic [2*RW-1:0]   q_in;
        logic [SIDE_W-1:0] side_in;
        logic [RMW+1:0]    shifted;
        logic [RMW+1:0]    trial;
        logic              ge;
        logic [RMW+1:0]    diff;

        if (j == 0) begin : g_first
            assign v_in    = dv_reg[QW-1];
            assign rem_in  = '0;
            assign root_in = '0;
            assign q_in    = q_pad;
            assign side_in = dside_reg[QW-1];
        end else begin : g_next
            assign v_in    = sv_reg[j-1];
            assign rem_in  = srem_reg[j-1];
            assign root_in = sroot_reg[j-1];
            assign q_in    = sq_reg[j-1];
            assign side_in = sside_reg[j-1];
        end

        assign shifted = {rem_in, q_in[2*P+1 -: 2]};
        assign trial   = (RMW+2)'({root_in, 2'b01});
        assign ge      = shifted >= trial;
        assign diff    = shifted - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[j]  <= ge ? diff[RMW-1:0] : shifted[RMW-1:0];
                sroot_reg[j] <= {root_in[RW-2:0], ge};
                sq_reg[j]    <= q_in;
                sside_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = sv_reg[RW-1];
    assign root      = sroot_reg[RW-1];
    assign out_side  = sside_reg[RW-1];

endmodule
